// File: src/ordered_list_store_core_assert.svh
// Assertion macros for the ordered list store.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef ORDERED_LIST_STORE_CORE_ASSERT_SVH
`define ORDERED_LIST_STORE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define OLS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define OLS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/ols_pkg.sv
// Shared types and constants of the ordered list store.
// No dependencies; used by the channel interfaces and the core.
`timescale 1ns / 1ps
`default_nettype none

package ols_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // fixed field widths of the channels
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned LEN_W    = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_SWAP   = 2'd2,
    KIND_READ   = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_TOO_FEW   = 3'd4,
    ST_ELEMENT   = 3'd5
  } status_e;

endpackage

`default_nettype wire

// File: src/ols_if.sv
// Valid/ready channels of the ordered list store: command in, result out.
// Depends on ols_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ols_in_if;
  import ols_pkg::*;
  logic               valid;
  logic               ready;
  kind_e              kind;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface ols_out_if;
  import ols_pkg::*;
  logic               valid;
  logic               ready;
  status_e            status;
  logic [VALUE_W-1:0] item_value;
  logic [LEN_W-1:0]   length;
  logic               last;

  modport source (output valid, output status, output item_value, output length,
                  output last, input ready);
  modport sink   (input valid, input status, input item_value, input length,
                  input last, output ready);
endinterface

`default_nettype wire

// File: src/ordered_list_store_core.sv
// Ordered list store core; depends on ols_pkg, ols_if.sv and ordered_list_store_core_assert.svh.
// Per command: append writes the entry; swap reads two entries, then writes each to the
// other's place; delete searches, then shifts the tail, one entry a cycle through the memory
// port; read returns the elements in order, one element a cycle while the output is taken.
// One item at a time: the next one is taken the cycle after its last result item is loaded.
// Reset (async, active low) empties the list; memory contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_store_core #(
  parameter int unsigned DEPTH      = ols_pkg::DEPTH_DEF,
  parameter int unsigned VALUE_BITS = ols_pkg::VALUE_BITS_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  ols_in_if.sink     in_i,
  ols_out_if.source  out_o
);
  import ols_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = $clog2(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SEARCH,
    S_SHIFT,
    S_SWAP_A,
    S_SWAP_B,
    S_SWAP_C,
    S_READ,
    S_RESP
  } state_e;

  state_e               state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        ptr_q, ptr_d;
  logic [CW-1:0]        didx_q, didx_d;
  logic                 dvld_q, dvld_d;
  kind_e                kind_q, kind_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [VALUE_BITS-1:0] hold_q, hold_d;
  status_e              status_q, status_d;

  logic                 out_valid_q, out_valid_d;
  status_e              out_status_q, out_status_d;
  logic [VALUE_W-1:0]   out_value_q, out_value_d;
  logic [LEN_W-1:0]     out_len_q, out_len_d;
  logic                 out_last_q, out_last_d;

  // memory port
  logic [VALUE_BITS-1:0] mem [DEPTH];
  logic [VALUE_BITS-1:0] rdata_q;
  logic                  rd_en, we;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic [VALUE_BITS-1:0] wdata;

  logic          out_free;
  logic          issue;
  logic [CW-1:0] ptr_inc, didx_m1, count_m1, swap_pos;

  assign out_free = !out_valid_q || out_o.ready;
  assign ptr_inc  = ptr_q + CW'(1);
  assign didx_m1  = didx_q - CW'(1);
  assign count_m1 = count_q - CW'(1);
  assign swap_pos = count_q - CW'(2);
  assign issue    = (ptr_q < count_q);

  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.item_value = out_value_q;
  assign out_o.length     = out_len_q;
  assign out_o.last       = out_last_q;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    ptr_d        = ptr_q;
    didx_d       = didx_q;
    dvld_d       = 1'b0;
    kind_d       = kind_q;
    val_d        = val_q;
    hold_d       = hold_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_len_d    = out_len_q;
    out_last_d   = out_last_q;
    rd_en        = 1'b0;
    rd_addr      = ptr_q[AW-1:0];
    we           = 1'b0;
    wr_addr      = count_q[AW-1:0];
    wdata        = val_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          kind_d  = in_i.kind;
          val_d   = VALUE_BITS'(in_i.value);
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        ptr_d = '0;
        unique case (kind_q)
          KIND_APPEND: begin
            if (count_q >= CW'(DEPTH)) begin
              status_d = ST_FULL;
            end else begin
              we       = 1'b1;
              count_d  = count_q + CW'(1);
              status_d = ST_DONE;
            end
            state_d = S_RESP;
          end
          KIND_DELETE: begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
              state_d  = S_RESP;
            end else begin
              state_d = S_SEARCH;
            end
          end
          KIND_SWAP: begin
            if (count_q < CW'(2)) begin
              status_d = ST_TOO_FEW;
              state_d  = S_RESP;
            end else begin
              rd_en   = 1'b1;
              rd_addr = AW'(1);
              state_d = S_SWAP_A;
            end
          end
          KIND_READ: begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
              state_d  = S_RESP;
            end else begin
              rd_en   = 1'b1;
              rd_addr = '0;
              state_d = S_READ;
            end
          end
        endcase
      end
      S_SEARCH: begin
        // read at ptr, compare the entry read in the previous cycle
        rd_en  = issue;
        dvld_d = issue;
        didx_d = ptr_q;
        if (issue) ptr_d = ptr_inc;
        if (dvld_q) begin
          if (rdata_q == val_q) begin
            ptr_d   = didx_q + CW'(1);
            dvld_d  = 1'b0;
            state_d = S_SHIFT;
          end else if (didx_q == count_m1) begin
            status_d = ST_NOT_FOUND;
            state_d  = S_RESP;
          end
        end
      end
      S_SHIFT: begin
        // read entry j+1, write it to j in the next cycle
        rd_en  = issue;
        dvld_d = issue;
        didx_d = ptr_q;
        if (issue) ptr_d = ptr_inc;
        if (dvld_q) begin
          we      = 1'b1;
          wr_addr = didx_m1[AW-1:0];
          wdata   = rdata_q;
        end
        if (!issue && !dvld_q) begin
          count_d  = count_m1;
          status_d = ST_DONE;
          state_d  = S_RESP;
        end
      end
      S_SWAP_A: begin
        hold_d  = rdata_q;
        rd_en   = 1'b1;
        rd_addr = swap_pos[AW-1:0];
        state_d = S_SWAP_B;
      end
      S_SWAP_B: begin
        we      = 1'b1;
        wr_addr = AW'(1);
        wdata   = rdata_q;
        state_d = S_SWAP_C;
      end
      S_SWAP_C: begin
        we       = 1'b1;
        wr_addr  = swap_pos[AW-1:0];
        wdata    = hold_q;
        status_d = ST_DONE;
        state_d  = S_RESP;
      end
      S_READ: begin
        // rdata_q holds entry ptr; it stays until the output takes it
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_ELEMENT;
          out_value_d  = VALUE_W'(rdata_q);
          out_len_d    = LEN_W'(count_q);
          out_last_d   = (ptr_inc == count_q);
          if (ptr_inc == count_q) begin
            state_d = S_IDLE;
          end else begin
            ptr_d   = ptr_inc;
            rd_en   = 1'b1;
            rd_addr = ptr_inc[AW-1:0];
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_value_d  = '0;
          out_len_d    = LEN_W'(count_q);
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      ptr_q        <= '0;
      didx_q       <= '0;
      dvld_q       <= 1'b0;
      kind_q       <= KIND_APPEND;
      val_q        <= '0;
      hold_q       <= '0;
      status_q     <= ST_DONE;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_DONE;
      out_value_q  <= '0;
      out_len_q    <= '0;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      ptr_q        <= ptr_d;
      didx_q       <= didx_d;
      dvld_q       <= dvld_d;
      kind_q       <= kind_d;
      val_q        <= val_d;
      hold_q       <= hold_d;
      status_q     <= status_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_value_q  <= out_value_d;
      out_len_q    <= out_len_d;
      out_last_q   <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= mem[rd_addr];
    if (we) mem[wr_addr] <= wdata;
  end

`include "ordered_list_store_core_assert.svh"

  `OLS_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(DEPTH), "count above depth")
  `OLS_ASSERT_NEXT(a_append_grows,
      state_q == S_DISPATCH && kind_q == KIND_APPEND && count_q < CW'(DEPTH),
      count_q == $past(count_q) + CW'(1), "append did not grow the list")
  `OLS_ASSERT_NOW(a_shift_write_range, state_q == S_SHIFT && dvld_q,
      didx_q < count_q && didx_q != '0, "shift writes outside the list")
  `OLS_ASSERT_NOW(a_read_last, state_q == S_READ && out_free && ptr_inc == count_q,
      out_last_d, "final element not marked last")

endmodule

`default_nettype wire
